@@ hdl/gbn_pkg.sv @@
// Package for the greedy box suppression block: payload and store types,
// sequencer states, widths and the inclusive span helper.
// No dependencies.
package gbn_pkg;

  // Defaults and fixed widths
  localparam int unsigned MAX_KEPT_DEF   = 64;
  localparam logic [7:0]  THR_RESET      = 8'd77;
  localparam int          PIXEL_UNIT     = 16;
  localparam int          COORD_W        = 16;
  localparam int          SPAN_W         = 17;
  localparam int          AREA_W         = 34;
  localparam int          UNI_W          = 35;
  localparam int          RHS_W          = 43;
  localparam int          MUL_A_W        = 35;
  localparam int          MUL_B_W        = 17;
  localparam int          PROD_W         = MUL_A_W + MUL_B_W;
  localparam int          ITEM_W         = 10;

  // One input box
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [7:0]                class_label;
    logic                      first_of_set;
  } box_in_t;

  // One result
  typedef struct packed {
    logic              keep;
    logic [7:0]        label_out;
    logic [ITEM_W-1:0] item_number;
    logic              store_overflow;
  } result_t;

  // Store entry: corners plus the area worked out when it was kept
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [AREA_W-1:0]         area;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CSPAN,
    S_AREA,
    S_READ,
    S_GEOM,
    S_INTER,
    S_UNION,
    S_SCALE,
    S_CMP,
    S_DONE
  } state_e;

  // Inclusive extent hi - lo + one pixel, clamped at zero
  function automatic logic [SPAN_W-1:0] span(input logic signed [COORD_W-1:0] lo,
                                             input logic signed [COORD_W-1:0] hi);
    logic signed [SPAN_W:0] s;
    s = (SPAN_W+1)'(hi) - (SPAN_W+1)'(lo) + $signed((SPAN_W+1)'(PIXEL_UNIT));
    return (s > 0) ? s[SPAN_W-1:0] : '0;
  endfunction

endpackage

@@ hdl/greedy_box_nms.sv @@
// Greedy class-agnostic box suppression with one shared multiplier.
// Depends on gbn_pkg for payload types, states and the span helper.
//
// Each box is checked against the store entries in order, up to the store fill,
// with an early exit on the first hit. The input is stalled while a box is
// worked, so a new box is taken only once the previous result is registered.
// Each stored entry takes six sequencer steps around the one multiplier
// (read, geometry, intersection, union, scaling, compare).
// Reset: asynchronous, active low; store fill, item count and the result valid
// clear, the threshold returns to 77/256. Store contents are not cleared.
module greedy_box_nms
  import gbn_pkg::*;
#(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  box_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  state_e            state_q, state_d;
  box_in_t           cur_q;
  logic [ITEM_W-1:0] item_q, cur_item_q, next_item;
  logic [CNT_W-1:0]  count_q, scan_q;
  logic [SPAN_W-1:0] cw_q, ch_q, iw_q, ih_q, iw_d, ih_d;
  logic [AREA_W-1:0] area_a_q, inter_q;
  logic [UNI_W-1:0]  union_q;
  logic [UNI_W:0]    union_full;
  logic [RHS_W-1:0]  rhs_q;
  logic              keep_q, hit, done_fire, store_ok;
  logic [7:0]        thr_q;
  entry_t            rd_q;
  entry_t            kept_q [MAX_KEPT];
  result_t           out_q;
  logic              out_valid_q;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic signed [COORD_W-1:0] ix1, iy1, ix2, iy2;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // Shared multiplier
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Intersection geometry against the entry just read
  always_comb begin
    ix1  = (cur_q.left   > rd_q.left)   ? cur_q.left   : rd_q.left;
    iy1  = (cur_q.top    > rd_q.top)    ? cur_q.top    : rd_q.top;
    ix2  = (cur_q.right  < rd_q.right)  ? cur_q.right  : rd_q.right;
    iy2  = (cur_q.bottom < rd_q.bottom) ? cur_q.bottom : rd_q.bottom;
    iw_d = span(ix1, ix2);
    ih_d = span(iy1, iy2);
  end

  assign union_full = (UNI_W+1)'(area_a_q) + (UNI_W+1)'(rd_q.area)
                    - (UNI_W+1)'(inter_q);
  assign hit        = RHS_W'({inter_q, 8'h00}) > rhs_q;
  assign next_item  = in_data_i.first_of_set ? '0 : item_q;
  assign store_ok   = keep_q && (count_q < CNT_W'(MAX_KEPT));

  // Sequencer: next state, multiplier operands, stall
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    done_fire  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = S_CSPAN;
      end
      S_CSPAN: state_d = S_AREA;
      S_AREA: begin
        mul_a   = MUL_A_W'(cw_q);
        mul_b   = ch_q;
        state_d = (count_q == '0) ? S_DONE : S_READ;
      end
      S_READ:  state_d = S_GEOM;
      S_GEOM:  state_d = S_INTER;
      S_INTER: begin
        mul_a   = MUL_A_W'(iw_q);
        mul_b   = ih_q;
        state_d = S_UNION;
      end
      S_UNION: state_d = S_SCALE;
      S_SCALE: begin
        mul_a   = union_q;
        mul_b   = MUL_B_W'(thr_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit || ((scan_q + CNT_W'(1)) == count_q)) state_d = S_DONE;
        else                                          state_d = S_READ;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          done_fire = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i) begin
        item_q <= next_item + ITEM_W'(1);
        if (in_data_i.first_of_set) count_q <= '0;
      end
      if (done_fire && store_ok) count_q <= count_q + CNT_W'(1);
      if (done_fire)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_q      <= in_data_i;
          cur_item_q <= next_item;
          keep_q     <= 1'b1;
          scan_q     <= '0;
        end
      end
      S_CSPAN: begin
        cw_q <= span(cur_q.left, cur_q.right);
        ch_q <= span(cur_q.top, cur_q.bottom);
      end
      S_AREA:  area_a_q <= prod[AREA_W-1:0];
      S_READ:  rd_q     <= kept_q[scan_q[IDX_W-1:0]];
      S_GEOM: begin
        iw_q <= iw_d;
        ih_q <= ih_d;
      end
      S_INTER: inter_q <= prod[AREA_W-1:0];
      S_UNION: union_q <= union_full[UNI_W] ? '0 : union_full[UNI_W-1:0];
      S_SCALE: rhs_q   <= prod[RHS_W-1:0];
      S_CMP: begin
        if (hit) keep_q <= 1'b0;
        scan_q <= scan_q + CNT_W'(1);
      end
      S_DONE: begin
        if (done_fire) begin
          out_q.keep           <= keep_q;
          out_q.label_out      <= cur_q.class_label;
          out_q.item_number    <= cur_item_q;
          out_q.store_overflow <= keep_q && !store_ok;
        end
      end
      default: ;
    endcase
  end

  // Append a surviving box to the store
  always_ff @(posedge clk_i) begin
    if (done_fire && store_ok) begin
      kept_q[count_q[IDX_W-1:0]] <= '{left:   cur_q.left,
                                      top:    cur_q.top,
                                      right:  cur_q.right,
                                      bottom: cur_q.bottom,
                                      area:   area_a_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_CSPAN)
    else $error("accepted box did not start the sequencer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEPT))
    else $error("store fill beyond capacity");

  a_scan_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> scan_q < count_q)
    else $error("store read beyond fill");

  a_overflow_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.keep || !out_data_o.store_overflow))
    else $error("overflow flagged on a suppressed box");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the finishing step");

endmodule

@@ tb/sv/gbn_checker.sv @@
`timescale 1ns / 100ps
// Checker for greedy_box_nms: watches the input, result and threshold channels,
// predicts each verdict with its own copy of the kept-box store and compares.
// Depends on gbn_pkg for the payload types and widths.
module gbn_checker
  import gbn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  box_in_t    in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  result_t    out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  output int         outstanding_o,
  output int         errors_o
);

  localparam int STORE_DEPTH = MAX_KEPT_DEF;

  // Shadow of the block's state
  box_in_t           kept_shadow [STORE_DEPTH];
  int                kept_fill;
  logic [ITEM_W-1:0] set_position;
  logic [7:0]        iou_limit;
  result_t           awaited_verdicts [$];

  // Inclusive extent in Q12.4 units, clamped at zero
  function automatic longint extent(input int lo, input int hi);
    longint s;
    s = longint'(hi) - longint'(lo) + PIXEL_UNIT;
    return (s > 0) ? s : 0;
  endfunction

  // True when the IoU of the two boxes is above the threshold
  function automatic bit overlap_exceeds(input box_in_t a, input box_in_t b);
    int     al, at, ar, ab, bl, bt, br, bb;
    longint area_a, area_b, inter, uni, thr;
    al = int'(a.left);  at = int'(a.top);
    ar = int'(a.right); ab = int'(a.bottom);
    bl = int'(b.left);  bt = int'(b.top);
    br = int'(b.right); bb = int'(b.bottom);
    area_a = extent(al, ar) * extent(at, ab);
    area_b = extent(bl, br) * extent(bt, bb);
    inter  = extent((al > bl) ? al : bl, (ar < br) ? ar : br) *
             extent((at > bt) ? at : bt, (ab < bb) ? ab : bb);
    uni    = area_a + area_b - inter;
    if (uni < 0) uni = 0;
    thr = longint'(iou_limit);
    return (inter * 256) > (thr * uni);
  endfunction

  // Verdict for one box; updates the shadow store and set position
  function automatic result_t predict_verdict(input box_in_t b);
    result_t r;
    bit      suppressed;
    if (b.first_of_set) begin
      kept_fill    = 0;
      set_position = '0;
    end
    suppressed = 1'b0;
    for (int i = 0; i < kept_fill; i++) begin
      if (!suppressed && overlap_exceeds(kept_shadow[i], b)) suppressed = 1'b1;
    end
    r.keep           = !suppressed;
    r.label_out      = b.class_label;
    r.item_number    = set_position;
    r.store_overflow = 1'b0;
    // Append survivors; a full store keeps the box but flags it
    if (!suppressed) begin
      if (kept_fill < STORE_DEPTH) begin
        kept_shadow[kept_fill] = b;
        kept_fill++;
      end else begin
        r.store_overflow = 1'b1;
      end
    end
    set_position++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    errors_o++;
  endtask

  // Apply threshold writes, check results, then predict new transfers
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      awaited_verdicts.delete();
      kept_fill     = 0;
      set_position  = '0;
      iou_limit     = THR_RESET;
      errors_o      = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) iou_limit = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_verdicts.size() == 0) begin
          report_mismatch("result with no box awaiting it", 32'(out_data_i), '0);
        end else begin
          want = awaited_verdicts.pop_front();
          if (out_data_i.keep !== want.keep)
            report_mismatch("keep", 32'(out_data_i.keep), 32'(want.keep));
          if (out_data_i.label_out !== want.label_out)
            report_mismatch("label_out", 32'(out_data_i.label_out),
                            32'(want.label_out));
          if (out_data_i.item_number !== want.item_number)
            report_mismatch("item_number", 32'(out_data_i.item_number),
                            32'(want.item_number));
          if (out_data_i.store_overflow !== want.store_overflow)
            report_mismatch("store_overflow", 32'(out_data_i.store_overflow),
                            32'(want.store_overflow));
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_verdicts.insert(awaited_verdicts.size(), predict_verdict(in_data_i));
      outstanding_o <= awaited_verdicts.size();
    end
  end

endmodule

@@ tb/sv/tb_greedy_box_nms.sv @@
`timescale 1ns / 100ps
// Top of the greedy_box_nms testbench: clock, reset, box and threshold stimulus,
// result sink with random hold-off, watchdog and verdict. Uses gbn_checker, gbn_pkg.
module tb_greedy_box_nms;
  import gbn_pkg::*;

  // The longest quiet stretch of a correct run is the long hold-off; one box
  // against a full store is shorter.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_OFF    = 600;
  localparam int DRAIN_WAIT  = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  box_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  result_t    out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;
  int         outstanding;
  int         errors;
  int         quiet = 0;
  bit         sender_calm = 1'b0;
  int         centre_x [4];
  int         centre_y [4];

  always #10 clk = ~clk;

  greedy_box_nms dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  gbn_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  function automatic box_in_t make_box(input int l, input int t, input int r, input int b,
                                       input int label, input bit first);
    box_in_t x;
    x.left         = l[15:0];
    x.top          = t[15:0];
    x.right        = r[15:0];
    x.bottom       = b[15:0];
    x.class_label  = label[7:0];
    x.first_of_set = first;
    return x;
  endfunction

  // Random box: half clustered near the set's centres, plus disjoint tiles,
  // full-range corners, thin or empty boxes and boxes at the coordinate limits
  function automatic box_in_t random_box();
    int kind, c, w, h, l, t, r, b;
    kind = $urandom_range(0, 9);
    c    = $urandom_range(0, 3);
    w    = $urandom_range(32, 400);
    h    = $urandom_range(32, 400);
    case (kind)
      0, 1, 2, 3, 4: begin
        l = centre_x[c] + $urandom_range(0, 96) - 48 - w / 2;
        t = centre_y[c] + $urandom_range(0, 96) - 48 - h / 2;
        r = l + w - 16;
        b = t + h - 16;
      end
      5, 6: begin
        l = $urandom_range(0, 63) * 512 - 16384;
        t = $urandom_range(0, 63) * 512 - 16384;
        r = l + w - 16;
        b = t + h - 16;
      end
      7: begin
        l = $urandom;
        t = $urandom;
        r = $urandom;
        b = $urandom;
      end
      8: begin
        l = $urandom_range(0, 65535) - 32768;
        t = $urandom_range(0, 65535) - 32768;
        r = l - $urandom_range(0, 40);
        b = t + $urandom_range(0, 300);
      end
      default: begin
        l = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 500)
                                 : -32768 + $urandom_range(0, 500);
        t = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 500)
                                 : -32768 + $urandom_range(0, 500);
        r = $urandom_range(0, 1) ? 32767 : l + w;
        b = $urandom_range(0, 1) ? -32768 : t + h;
      end
    endcase
    return make_box(l, t, r, b, $urandom, 1'b0);
  endfunction

  // Offer one box after a random gap and hold it until transferred
  task automatic send_box(input box_in_t b);
    int gap;
    if ($urandom_range(0, 24) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain the block, then write the threshold
  task automatic write_threshold(input logic [7:0] thr);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_data  <= thr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One set of boxes; with noise, sets may continue the previous one or restart midway
  task automatic run_set(input int len, input bit with_noise);
    box_in_t b;
    bit      carry_on;
    for (int i = 0; i < 4; i++) begin
      centre_x[i] = $urandom_range(0, 40000) - 20000;
      centre_y[i] = $urandom_range(0, 40000) - 20000;
    end
    carry_on = with_noise && ($urandom_range(0, 7) == 0);
    for (int k = 0; k < len; k++) begin
      b = random_box();
      b.first_of_set = (k == 0 && !carry_on) || (with_noise && $urandom_range(0, 39) == 0);
      send_box(b);
    end
  endtask

  task automatic run_random(input int count);
    int remaining, len;
    remaining = count;
    while (remaining > 0) begin
      len = $urandom_range(1, 40);
      if (len > remaining) len = remaining;
      run_set(len, 1'b1);
      remaining -= len;
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset threshold: identical, empty, inverted, thin and shifted boxes
    send_box(make_box(0, 0, 159, 159, 0, 1'b1));
    send_box(make_box(0, 0, 159, 159, 255, 1'b0));
    send_box(make_box(-32768, -32768, 32767, 32767, 'ha5, 1'b0));
    send_box(make_box(100, 100, -100, -100, 3, 1'b0));
    send_box(make_box(16, 16, 0, 0, 4, 1'b0));
    // empty against empty store entries: zero union keeps it
    send_box(make_box(50, 50, 20, 20, 5, 1'b0));
    send_box(make_box(300, 300, 285, 285, 6, 1'b0));
    send_box(make_box(80, 0, 239, 159, 7, 1'b0));
    send_box(make_box(120, 0, 279, 159, 8, 1'b0));
    send_box(make_box(32767, 32767, 32767, 32767, 9, 1'b1));
    send_box(make_box(-32768, -32768, -32768, -32768, 'h5a, 1'b0));
    send_box(make_box(32767, -32768, -32768, 32767, 10, 1'b0));

    // Half threshold: exactly equal IoU is kept, one unit more is suppressed
    write_threshold(8'd128);
    send_box(make_box(0, 0, 176, 176, 11, 1'b1));
    send_box(make_box(64, 0, 240, 176, 12, 1'b0));
    send_box(make_box(63, 0, 239, 176, 13, 1'b0));

    // Zero threshold: any overlap suppresses
    write_threshold(8'd0);
    send_box(make_box(0, 0, 159, 159, 14, 1'b1));
    send_box(make_box(159, 159, 400, 400, 15, 1'b0));
    send_box(make_box(176, 0, 400, 159, 16, 1'b0));
    run_random(80);

    // Top threshold: only a near-identical box is suppressed
    write_threshold(8'd255);
    send_box(make_box(0, 0, 159, 159, 17, 1'b1));
    send_box(make_box(0, 0, 159, 159, 18, 1'b0));
    send_box(make_box(1, 0, 160, 159, 19, 1'b0));
    run_random(80);

    // One long set: fills the store and wraps the item count
    write_threshold(8'd77);
    run_set(1060, 1'b0);

    write_threshold(8'($urandom_range(1, 254)));
    run_random(80);

    write_threshold(8'd200);
    run_random(80);

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result sink: random hold-off per result, calm stretches, one long hold-off
  initial begin
    int  hold;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 17);
      if (taken == 400) hold = HOLD_OFF;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
